@@ sv/assert_macros.svh @@
// Assertion macros shared by the maze generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("maze generator check failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_CHK(lbl, !(cond))

`endif

@@ sv/mdg_pkg.sv @@
// Package for the maze generator: codes, constants and the draw unit functions.
package mdg_pkg;

  // Default grid limits
  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_HEIGHT_DEF = 32;

  // Width of dimension compares; covers limits up to 511
  localparam int DIM_W = 9;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_START_X     = 2'd2;
  localparam logic [1:0] CFG_START_Y     = 2'd3;

  // Configuration reset values
  localparam logic [5:0] GRID_WIDTH_RST  = 6'd32;
  localparam logic [5:0] GRID_HEIGHT_RST = 6'd32;
  localparam logic [4:0] START_X_RST     = 5'd3;
  localparam logic [4:0] START_Y_RST     = 5'd2;

  // Request kinds
  localparam logic REQ_GENERATE = 1'b0;
  localparam logic REQ_READ     = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_START = 2'd1;
  localparam logic [1:0] STATUS_BAD_CELL  = 2'd2;

  // Cell store bits
  localparam logic [2:0] WALL_BOT   = 3'b001;
  localparam logic [2:0] WALL_RIGHT = 3'b010;
  localparam logic [2:0] VISITED    = 3'b100;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] LFSR_RST  = 16'h0001;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_START,
    ST_SHUF,
    ST_STEP,
    ST_TEST,
    ST_HERE,
    ST_MARK,
    ST_PUSH,
    ST_POP,
    ST_FIN,
    ST_READ
  } state_t;

  // One Galois LFSR advance
  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] r;
    r = v >> 1;
    if (v[0]) r = r ^ LFSR_TAPS;
    return r;
  endfunction

  // Residue mod 3: base-4 digits sum, then fold (4 is 1 mod 3)
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] a;
    logic [2:0] b;
    s = '0;
    for (int k = 0; k < 8; k++) s = s + 5'(v[2*k +: 2]);
    a = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    b = 3'(a[1:0]) + 3'(a[2]);
    if (b >= 3'd3) b = b - 3'd3;
    return b[1:0];
  endfunction

endpackage

@@ sv/maze_dfs_generator.sv @@
// Maze generator top level: depth-first walk sequencer, cell store and walk stack.
//
// Usage: a request is taken at a clock edge where start is high and busy is low.
// req_type 0 generates a new maze from seed, req_type 1 reads one cell's bottom
// and right walls. Each request gives exactly one result, shown for one cycle
// with done high; the receiver cannot hold it off. Registers are written through
// cfg_wr_en / cfg_index / cfg_wdata with no wait; the user must write them only
// while busy is low, as the block itself does not enforce it. A read passes the
// ST_READ state, which reads the cell store, and then the done register; a read
// outside the grid or a generate with a bad start goes from idle straight to the
// done register. A generate first sweeps the cell store, one entry a cycle
// (2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries, 1024 by default), then walks:
// per cell a shuffle on the shared LFSR/modulo unit, a STEP per direction tried, a
// TEST per neighbour in the grid, a PUSH per carve with HERE and MARK before it for
// a right or down carve, and a POP per backtrack. The single write port of the cell
// store sets the pace of the walk. busy stays high until the result is registered.
// Reset: the same sweep runs after reset with busy high, leaving every cell
// walled and unvisited; registers take their reset values.
module maze_dfs_generator #(
  parameter int MAX_WIDTH  = mdg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mdg_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [15:0] seed,
  input  logic [4:0]  cell_x,
  input  logic [4:0]  cell_y,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata,
  output logic        done,
  output logic        resp_kind,
  output logic [1:0]  status,
  output logic        wall_bottom,
  output logic        wall_right,
  output logic [4:0]  exit_x,
  output logic [4:0]  exit_y
);
  import mdg_pkg::*;

`include "assert_macros.svh"

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;
  localparam int SP_W  = AW + 1;

  // One stack frame: cell, direction order, next try, dead-end flag
  typedef struct packed {
    logic [YW-1:0]   y;
    logic [XW-1:0]   x;
    logic [3:0][1:0] order;
    logic [2:0]      idx;
    logic            dead_end;
  } frame_t;

  state_t state, state_next;

  // Configuration registers
  logic [5:0] grid_width, grid_height;
  logic [4:0] start_x, start_y;

  // Walk registers
  frame_t         cur;
  logic [SP_W-1:0] sp;
  logic [1:0]     shuf_i;
  logic [15:0]    lfsr;
  logic [AW-1:0]  clr_addr;
  logic           gen_pending;
  logic [XW-1:0]  tgt_x;
  logic [YW-1:0]  tgt_y;
  dir_t           tgt_dir;
  logic [2:0]     tgt_val;
  logic [XW-1:0]  exit_x_r;
  logic [YW-1:0]  exit_y_r;
  logic           exit_found;

  // Memories
  logic [2:0] cell_mem [DEPTH];
  frame_t     stack_mem [DEPTH];
  logic [2:0] cell_rdata;
  frame_t     stack_rdata;

  logic          cell_we;
  logic [AW-1:0] cell_waddr, cell_raddr;
  logic [2:0]    cell_wdata;
  logic          stack_we;
  logic [AW-1:0] stack_waddr, stack_raddr;

  logic [SP_W-1:0] sp_m1, sp_m2;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic             accept, start_bad, read_bad;
  logic [XW-1:0]    sx, rx;
  logic [YW-1:0]    sy, ry;

  dir_t          d;
  logic          inb;
  logic [XW-1:0] nx;
  logic [YW-1:0] ny;

  logic [15:0]     draw;
  logic [1:0]      draw_j;
  logic [3:0][1:0] order_sw;

  logic       res_valid, res_kind, res_bot, res_right;
  logic [1:0] res_status;
  logic [4:0] res_ex, res_ey;

  // Effective dimensions and request checks
  always_comb begin
    w_eff = (DIM_W'(grid_width) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(grid_width);
    h_eff = (DIM_W'(grid_height) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                        : DIM_W'(grid_height);
    start_bad = (DIM_W'(start_x) >= w_eff) || (DIM_W'(start_y) >= h_eff);
    read_bad  = (DIM_W'(cell_x) >= w_eff) || (DIM_W'(cell_y) >= h_eff);
    sx = XW'(start_x);
    sy = YW'(start_y);
    rx = XW'(cell_x);
    ry = YW'(cell_y);
  end

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign sp_m1  = sp - SP_W'(1);
  assign sp_m2  = sp - SP_W'(2);

  // Neighbour of the top frame in its next direction
  always_comb begin
    d   = dir_t'(cur.order[cur.idx[1:0]]);
    nx  = cur.x;
    ny  = cur.y;
    inb = 1'b0;
    case (d)
      DIR_LEFT: begin
        inb = (cur.x != '0);
        nx  = cur.x - XW'(1);
      end
      DIR_RIGHT: begin
        inb = (DIM_W'(cur.x) + DIM_W'(1)) < w_eff;
        nx  = cur.x + XW'(1);
      end
      DIR_UP: begin
        inb = (DIM_W'(cur.y) + DIM_W'(1)) < h_eff;
        ny  = cur.y + YW'(1);
      end
      DIR_DOWN: begin
        inb = (cur.y != '0);
        ny  = cur.y - YW'(1);
      end
      default: inb = 1'b0;
    endcase
  end

  // Shared draw unit: LFSR advance and residue, then the swap
  always_comb begin
    draw = lfsr_step(lfsr);
    case (shuf_i)
      2'd3:    draw_j = draw[1:0];
      2'd2:    draw_j = mod3_16(draw);
      default: draw_j = {1'b0, draw[0]};
    endcase
    order_sw         = cur.order;
    order_sw[shuf_i] = cur.order[draw_j];
    order_sw[draw_j] = cur.order[shuf_i];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory controls and result
  always_comb begin
    state_next  = state;
    cell_we     = 1'b0;
    cell_waddr  = {tgt_y, tgt_x};
    cell_wdata  = tgt_val | VISITED;
    cell_raddr  = {cur.y, cur.x};
    stack_we    = 1'b0;
    stack_waddr = sp_m1[AW-1:0];
    stack_raddr = sp_m2[AW-1:0];
    res_valid   = 1'b0;
    res_kind    = REQ_GENERATE;
    res_status  = STATUS_OK;
    res_bot     = 1'b0;
    res_right   = 1'b0;
    res_ex      = '0;
    res_ey      = '0;
    case (state)
      ST_IDLE: begin
        cell_raddr = {ry, rx};
        if (accept) begin
          if (req_type == REQ_GENERATE) begin
            if (start_bad) begin
              res_valid  = 1'b1;
              res_status = STATUS_BAD_START;
            end else begin
              state_next = ST_CLEAR;
            end
          end else begin
            if (read_bad) begin
              res_valid  = 1'b1;
              res_kind   = REQ_READ;
              res_status = STATUS_BAD_CELL;
            end else begin
              state_next = ST_READ;
            end
          end
        end
      end
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_addr;
        cell_wdata = WALL_BOT | WALL_RIGHT;
        if (clr_addr == '1) state_next = gen_pending ? ST_START : ST_IDLE;
      end
      ST_START: begin
        cell_we    = 1'b1;
        cell_waddr = {sy, sx};
        cell_wdata = WALL_BOT | WALL_RIGHT | VISITED;
        state_next = ST_SHUF;
      end
      ST_SHUF: begin
        if (shuf_i == 2'd1) state_next = ST_STEP;
      end
      ST_STEP: begin
        cell_raddr = {ny, nx};
        if (!cur.idx[2]) begin
          if (inb) state_next = ST_TEST;
        end else begin
          state_next = (sp == SP_W'(1)) ? ST_FIN : ST_POP;
        end
      end
      ST_TEST: begin
        // visited neighbour: try the next direction
        if ((cell_rdata & VISITED) != '0) begin
          state_next = ST_STEP;
        end else if (tgt_dir == DIR_LEFT) begin
          cell_we    = 1'b1;
          cell_wdata = (cell_rdata & ~WALL_RIGHT) | VISITED;
          state_next = ST_PUSH;
        end else if (tgt_dir == DIR_UP) begin
          cell_we    = 1'b1;
          cell_wdata = (cell_rdata & ~WALL_BOT) | VISITED;
          state_next = ST_PUSH;
        end else begin
          state_next = ST_HERE;
        end
      end
      ST_HERE: begin
        // carve the wall owned by the current cell
        cell_we    = 1'b1;
        cell_waddr = {cur.y, cur.x};
        cell_wdata = cell_rdata & ~((tgt_dir == DIR_RIGHT) ? WALL_RIGHT : WALL_BOT);
        state_next = ST_MARK;
      end
      ST_MARK: begin
        cell_we    = 1'b1;
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        stack_we   = 1'b1;
        state_next = ST_SHUF;
      end
      ST_POP: begin
        state_next = ST_STEP;
      end
      ST_FIN: begin
        res_valid  = 1'b1;
        res_ex     = 5'(exit_x_r);
        res_ey     = 5'(exit_y_r);
        state_next = ST_IDLE;
      end
      ST_READ: begin
        res_valid  = 1'b1;
        res_kind   = REQ_READ;
        res_bot    = cell_rdata[0];
        res_right  = cell_rdata[1];
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Cell store
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    cell_rdata <= cell_mem[cell_raddr];
  end

  // Walk stack; the top frame lives in cur
  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= cur;
    stack_rdata <= stack_mem[stack_raddr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
      start_x     <= START_X_RST;
      start_y     <= START_Y_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_height <= cfg_wdata;
        CFG_START_X:     start_x     <= cfg_wdata[4:0];
        CFG_START_Y:     start_y     <= cfg_wdata[4:0];
        default:         grid_width  <= grid_width;
      endcase
    end
  end

  // Walk control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sp          <= '0;
      lfsr        <= LFSR_RST;
      clr_addr    <= '0;
      gen_pending <= 1'b0;
      exit_x_r    <= '0;
      exit_y_r    <= '0;
      exit_found  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (req_type == REQ_GENERATE) && !start_bad) begin
            lfsr        <= (seed == '0) ? LFSR_RST : seed;
            exit_found  <= 1'b0;
            exit_x_r    <= '0;
            exit_y_r    <= '0;
            clr_addr    <= '0;
            gen_pending <= 1'b1;
          end
        end
        ST_CLEAR: clr_addr <= clr_addr + AW'(1);
        ST_START: begin
          sp          <= SP_W'(1);
          gen_pending <= 1'b0;
        end
        ST_SHUF: lfsr <= draw;
        ST_STEP: begin
          // backtrack; the first dead end is the exit
          if (cur.idx[2]) begin
            if (cur.dead_end && !exit_found) begin
              exit_x_r   <= cur.x;
              exit_y_r   <= cur.y;
              exit_found <= 1'b1;
            end
            sp <= sp_m1;
          end
        end
        ST_PUSH: sp <= sp + SP_W'(1);
        default: sp <= sp;
      endcase
    end
  end

  // Top frame and carve target
  always_ff @(posedge clk) begin
    case (state)
      ST_START: begin
        cur.x        <= sx;
        cur.y        <= sy;
        cur.order    <= {DIR_DOWN, DIR_UP, DIR_RIGHT, DIR_LEFT};
        cur.idx      <= '0;
        cur.dead_end <= 1'b1;
        shuf_i       <= 2'd3;
      end
      ST_SHUF: begin
        cur.order <= order_sw;
        shuf_i    <= shuf_i - 2'd1;
      end
      ST_STEP: begin
        if (!cur.idx[2]) begin
          cur.idx <= cur.idx + 3'd1;
          tgt_x   <= nx;
          tgt_y   <= ny;
          tgt_dir <= d;
        end
      end
      ST_TEST: begin
        if ((cell_rdata & VISITED) == '0) begin
          cur.dead_end <= 1'b0;
          tgt_val      <= cell_rdata;
        end
      end
      ST_PUSH: begin
        cur.x        <= tgt_x;
        cur.y        <= tgt_y;
        cur.order    <= {DIR_DOWN, DIR_UP, DIR_RIGHT, DIR_LEFT};
        cur.idx      <= '0;
        cur.dead_end <= 1'b1;
        shuf_i       <= 2'd3;
      end
      ST_POP: cur <= stack_rdata;
      default: cur <= cur;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      resp_kind   <= res_kind;
      status      <= res_status;
      wall_bottom <= res_bot;
      wall_right  <= res_right;
      exit_x      <= res_ex;
      exit_y      <= res_ey;
    end
  end

  // Checks
  `ASSERT_CHK(a_idle_stack_empty, (state == ST_IDLE) |-> (sp == '0))
  `ASSERT_NEVER(a_sp_overflow, sp > SP_W'(DEPTH))
  `ASSERT_NEVER(a_push_on_empty, (state == ST_PUSH) && (sp == '0))
  `ASSERT_CHK(a_test_after_step, (state == ST_TEST) |-> ($past(state) == ST_STEP))
  `ASSERT_CHK(a_done_has_cause, done |-> ($past(start && !busy) || $past(busy)))

endmodule
